// ----- hw/rtl/crst_pkg.sv -----
// ----------------------------------------------------------------------------
// crst_pkg
// Shared constants, types and command/status structs of the span tessellator.
// ----------------------------------------------------------------------------
package crst_pkg;

	localparam int COORD_BITS  = 24;
	localparam int MAX_SPLIT   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int SPLIT_CAP   = (MAX_SPLIT < 1) ? 1 :
		((MAX_SPLIT > MAX_RESULTS) ? MAX_RESULTS : MAX_SPLIT);

	localparam int N_W   = 4;   // split count 1..8
	localparam int K_W   = 3;   // piece index
	localparam int S_W   = 26;  // knot step before halving
	localparam int SN_W  = 21;  // knot step after halving
	localparam int SUM_W = S_W + 2;
	localparam int T_W   = 25;  // scaled knots
	localparam int W_W   = T_W + 1;
	localparam int PV_W  = 37;  // pyramid values, +-2^35
	localparam int MA_W  = 38;
	localparam int MB_W  = 32;
	localparam int DV_W  = 40;  // divisor width
	localparam int DEV_W = 32;
	localparam int TOLG_W = 20;
	localparam int CFG_AW = 3;

	localparam logic [SUM_W-1:0] KNOT_LIMIT = SUM_W'(1048576);
	localparam logic [63:0] PYR_LIMIT = 64'h0000_0008_0000_0000;
	localparam longint DEV_LIMIT = 64'sd1073741824;
	localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;

	localparam logic REG_TOL  = 1'b0;
	localparam logic REG_BIAS = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PV_W-1:0] pyr_t;
	typedef logic signed [DEV_W-1:0] dev_t;

	typedef enum logic [2:0] {
		MS_NONE    = 3'd0,
		MS_CHORD_X = 3'd1,
		MS_CHORD_Y = 3'd2,
		MS_MIX_A   = 3'd3,
		MS_MIX_B   = 3'd4,
		MS_DEV_X   = 3'd5,
		MS_DEV_Y   = 3'd6,
		MS_TOL     = 3'd7
	} mul_sel_t;

	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
	} span_t;

	typedef struct packed {
		coord_t         out_x;
		coord_t         out_y;
		logic [K_W-1:0] piece_index;
		logic           last_point;
	} point_t;

	typedef struct packed {
		logic       load_in;
		mul_sel_t   mul_sel;
		logic       acc_load;
		logic       acc_add;
		logic       sqrt_go;
		logic       sqrt_knot;
		logic       s_store;
		logic [1:0] seg;
		logic       halve;
		logic       dev_init;
		logic       knot_load;
		logic [2:0] mix;
		logic       axis;
		logic       div_go;
		logic       div_need;
		logic       mix_store;
		logic       dev_store;
		logic       out_store;
		logic       n_compute;
		logic       k_inc;
		logic       out_push;
	} crst_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic knot_over;
		logic k_last;
		logic out_free;
	} crst_stat_t;

endpackage

// ----- hw/rtl/crst_if.sv -----
// ----------------------------------------------------------------------------
// crst channel interfaces
// Valid/ready channels for span input and tessellated point output.
// ----------------------------------------------------------------------------
interface crst_span_if import crst_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t p0_x;
	coord_t p0_y;
	coord_t p1_x;
	coord_t p1_y;
	coord_t p2_x;
	coord_t p2_y;
	coord_t p3_x;
	coord_t p3_y;

	modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
		input ready);
	modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
		output ready);
endinterface

interface crst_point_if import crst_pkg::*; ();
	logic           valid;
	logic           ready;
	coord_t         out_x;
	coord_t         out_y;
	logic [K_W-1:0] piece_index;
	logic           last_point;

	modport source (output valid, out_x, out_y, piece_index, last_point, input ready);
	modport sink (input valid, out_x, out_y, piece_index, last_point, output ready);
endinterface

// ----- hw/rtl/crst_sqrt.sv -----
// ----------------------------------------------------------------------------
// crst_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module crst_sqrt import crst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);
	localparam int R_W = 35;

	logic [63:0]    rad_q;
	logic [R_W-1:0] rem_q;
	logic [31:0]    root_q;
	logic [4:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [R_W-1:0] rem_sh;
	logic [R_W-1:0] trial;

	assign rem_sh = {rem_q[R_W-3:0], rad_q[63:62]};
	assign trial  = R_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ----- hw/rtl/crst_div.sv -----
// ----------------------------------------------------------------------------
// crst_div
// Unsigned restoring divider, 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crst_div import crst_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [63:0]     num,
	input  logic [DV_W-1:0] den,
	output logic            done,
	output logic [63:0]     quo,
	output logic [DV_W-1:0] rem
);
	logic [63:0]     quo_q;
	logic [DV_W-1:0] rem_q;
	logic [DV_W-1:0] den_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DV_W:0]   rem_sh;

	assign rem_sh = {rem_q, quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh[DV_W-1:0] - den_q;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DV_W-1:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ----- hw/rtl/crst_datapath.sv -----
// ----------------------------------------------------------------------------
// crst_datapath
// Point registers, knots, pyramid values, shared multiplier, root and divide
// units and the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
module crst_datapath import crst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crst_cmd_t   cmd,
	output crst_stat_t  stat,
	input  span_t       span_in,
	input  logic [15:0] curve_tolerance,
	input  logic [15:0] knot_bias,
	output point_t      pt,
	output logic        pt_valid,
	input  logic        pt_ready
);
	typedef logic signed [COORD_BITS:0] cdiff_t;

	localparam logic signed [MA_W-1:0] DEV_HI = MA_W'(DEV_LIMIT);
	localparam logic signed [PV_W-1:0] OUT_HI = PV_W'(COORD_MAX);

	coord_t px_q [4];
	coord_t py_q [4];
	logic [S_W-1:0] s0_q, s1_q, s2_q;
	logic [N_W-1:0] n_q;
	logic [K_W-1:0] k_q;
	logic [T_W-1:0] t1_q, t2_q, t3_q, t_q;
	pyr_t a1_q, a2_q, a3_q, b1_q, b2_q, r_q;
	dev_t dx_q, dy_q;
	coord_t ox_q, oy_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	point_t pt_q;
	logic   pt_valid_q;

	// chord of the selected segment
	coord_t ca_x, ca_y, cb_x, cb_y;
	cdiff_t diff_x, diff_y;
	logic [COORD_BITS:0] ux, uy, uxh, uyh;
	logic chord_half;
	logic [32:0] chord_len;
	logic [63:0] knot_rad;

	logic [31:0] sq_root;
	logic        sq_done;
	logic [63:0] sq_rad;

	always_comb begin
		case (cmd.seg)
			2'd0: begin
				ca_x = px_q[0]; ca_y = py_q[0]; cb_x = px_q[1]; cb_y = py_q[1];
			end
			2'd1: begin
				ca_x = px_q[1]; ca_y = py_q[1]; cb_x = px_q[2]; cb_y = py_q[2];
			end
			default: begin
				ca_x = px_q[2]; ca_y = py_q[2]; cb_x = px_q[3]; cb_y = py_q[3];
			end
		endcase
		diff_x = cdiff_t'(cb_x) - cdiff_t'(ca_x);
		diff_y = cdiff_t'(cb_y) - cdiff_t'(ca_y);
		ux = (diff_x < 0) ? unsigned'(-diff_x) : unsigned'(diff_x);
		uy = (diff_y < 0) ? unsigned'(-diff_y) : unsigned'(diff_y);
		chord_half = (64'(ux) >= 64'h8000_0000) || (64'(uy) >= 64'h8000_0000);
		uxh = chord_half ? (ux >> 1) : ux;
		uyh = chord_half ? (uy >> 1) : uy;
		chord_len = chord_half ? {sq_root, 1'b0} : {1'b0, sq_root};
		knot_rad = (64'(chord_len) + 64'(knot_bias)) << 16;
		sq_rad = cmd.sqrt_knot ? knot_rad : unsigned'(acc_q);
	end

	crst_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.sqrt_go),
		.rad   (sq_rad),
		.done  (sq_done),
		.root  (sq_root)
	);

	// knot steps
	logic [SUM_W-1:0] s_sum;
	logic knot_over;
	logic [SN_W-1:0] s0n, s1n, s2n;

	assign s_sum = SUM_W'(s0_q) + SUM_W'(s1_q) + SUM_W'(s2_q);
	assign knot_over = s_sum > KNOT_LIMIT;
	assign s0n = s0_q[SN_W-1:0];
	assign s1n = s1_q[SN_W-1:0];
	assign s2n = s2_q[SN_W-1:0];

	// knots for the current n and k
	logic [T_W-1:0] t1_n, t2_n, t3_n, t_n;
	always_comb begin
		t1_n = T_W'(n_q) * T_W'(s0n);
		t2_n = t1_n + T_W'(n_q) * T_W'(s1n);
		t3_n = t2_n + T_W'(n_q) * T_W'(s2n);
		t_n  = t1_n + T_W'(k_q) * T_W'(s1n);
	end

	// pyramid stage operands
	logic signed [W_W-1:0] wt, wt1mt, wt2mt, wt3mt, wtmt1, wtmt2;
	logic signed [W_W-1:0] wa, wb;
	pyr_t g0, g1, g2, g3, va, vb;
	logic [T_W-1:0] den;

	function automatic pyr_t guard(input coord_t c);
		return pyr_t'(c) <<< 4;
	endfunction

	always_comb begin
		wt    = signed'({1'b0, t_q});
		wt1mt = signed'({1'b0, t1_q}) - wt;
		wt2mt = signed'({1'b0, t2_q}) - wt;
		wt3mt = signed'({1'b0, t3_q}) - wt;
		wtmt1 = wt - signed'({1'b0, t1_q});
		wtmt2 = wt - signed'({1'b0, t2_q});
		g0 = guard(cmd.axis ? py_q[0] : px_q[0]);
		g1 = guard(cmd.axis ? py_q[1] : px_q[1]);
		g2 = guard(cmd.axis ? py_q[2] : px_q[2]);
		g3 = guard(cmd.axis ? py_q[3] : px_q[3]);
		case (cmd.mix)
			3'd0: begin
				wa = wt1mt; va = g0; wb = wt; vb = g1; den = t1_q;
			end
			3'd1: begin
				wa = wt2mt; va = g1; wb = wtmt1; vb = g2; den = t2_q - t1_q;
			end
			3'd2: begin
				wa = wt3mt; va = g2; wb = wtmt2; vb = g3; den = t3_q - t2_q;
			end
			3'd3: begin
				wa = wt2mt; va = a1_q; wb = wt; vb = a2_q; den = t2_q;
			end
			3'd4: begin
				wa = wt3mt; va = a2_q; wb = wtmt1; vb = a3_q; den = t3_q - t1_q;
			end
			default: begin
				wa = wt2mt; va = b1_q; wb = wtmt1; vb = b2_q; den = t2_q - t1_q;
			end
		endcase
	end

	// shared multiplier
	logic [TOLG_W-1:0] tolg;
	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic signed [MA_W+MB_W-1:0] prod_full;

	assign tolg = {((curve_tolerance == 16'd0) ? 16'd1 : curve_tolerance), 4'b0000};

	always_comb begin
		case (cmd.mul_sel)
			MS_CHORD_X: begin ma = MA_W'(uxh); mb = MB_W'(uxh); end
			MS_CHORD_Y: begin ma = MA_W'(uyh); mb = MB_W'(uyh); end
			MS_MIX_A:   begin ma = MA_W'(va);  mb = MB_W'(wa);  end
			MS_MIX_B:   begin ma = MA_W'(vb);  mb = MB_W'(wb);  end
			MS_DEV_X:   begin ma = MA_W'(dx_q); mb = MB_W'(dx_q); end
			MS_DEV_Y:   begin ma = MA_W'(dy_q); mb = MB_W'(dy_q); end
			MS_TOL:     begin ma = MA_W'(tolg); mb = MB_W'(tolg); end
			default:    begin ma = '0; mb = '0; end
		endcase
		prod_full = ma * mb;
	end

	// divider
	logic [63:0] acc_mag, div_num, div_quo, need;
	logic [DV_W-1:0] div_den, div_rem;
	logic div_done;

	assign acc_mag = acc_q[63] ? unsigned'(-acc_q) : unsigned'(acc_q);
	assign div_num = cmd.div_need ? unsigned'(acc_q) : acc_mag + 64'(den >> 1);
	assign div_den = cmd.div_need ? prod_q[DV_W-1:0] : DV_W'(den);

	crst_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// rounded and saturated stage result
	logic [PV_W-1:0] mix_mag;
	logic signed [PV_W-1:0] mix_magv;
	pyr_t mix_val;

	always_comb begin
		mix_mag  = (div_quo > PYR_LIMIT) ? PYR_LIMIT[PV_W-1:0] : div_quo[PV_W-1:0];
		mix_magv = signed'(mix_mag);
		mix_val  = acc_q[63] ? -mix_magv : mix_magv;
	end

	// deviation from the chord midpoint
	logic signed [MA_W-1:0] dsum, dv, dvc;
	always_comb begin
		dsum = cmd.axis ? (MA_W'(py_q[1]) + MA_W'(py_q[2]))
			: (MA_W'(px_q[1]) + MA_W'(px_q[2]));
		dv = MA_W'(r_q) - (dsum <<< 3);
		if (dv > DEV_HI)
			dvc = DEV_HI;
		else if (dv < -DEV_HI)
			dvc = -DEV_HI;
		else
			dvc = dv;
	end

	// back to coordinate units
	logic r_neg;
	logic signed [PV_W-1:0] r_mag, r_rnd, r_clip, r_out;
	always_comb begin
		r_neg  = r_q[PV_W-1];
		r_mag  = r_neg ? -r_q : r_q;
		r_rnd  = (r_mag + PV_W'(8)) >>> 4;
		r_clip = (r_rnd > OUT_HI) ? OUT_HI : r_rnd;
		r_out  = r_neg ? -r_clip : r_clip;
	end

	// split count from the ceil quotient
	logic [N_W-1:0] n_calc;
	logic k_last;
	assign need = div_quo + 64'(div_rem != '0);
	always_comb begin
		n_calc = N_W'(1);
		for (int i = 1; i < SPLIT_CAP; i++) begin
			if (need > 64'(i * i * i * i))
				n_calc = N_W'(i + 1);
		end
	end
	assign k_last = (N_W'(k_q) + N_W'(1)) == n_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q[0] <= span_in.p0_x; py_q[0] <= span_in.p0_y;
			px_q[1] <= span_in.p1_x; py_q[1] <= span_in.p1_y;
			px_q[2] <= span_in.p2_x; py_q[2] <= span_in.p2_y;
			px_q[3] <= span_in.p3_x; py_q[3] <= span_in.p3_y;
		end
		prod_q <= prod_full[63:0];
		if (cmd.acc_load)
			acc_q <= prod_q;
		else if (cmd.acc_add)
			acc_q <= acc_q + prod_q;
		if (cmd.s_store) begin
			case (cmd.seg)
				2'd0:    s0_q <= S_W'(sq_root);
				2'd1:    s1_q <= S_W'(sq_root);
				default: s2_q <= S_W'(sq_root);
			endcase
		end
		if (cmd.halve) begin
			if (knot_over) begin
				s0_q <= s0_q >> 1;
				s1_q <= s1_q >> 1;
				s2_q <= s2_q >> 1;
			end else begin
				// a zero step would collapse two knots
				if (s0_q == '0) s0_q <= S_W'(1);
				if (s1_q == '0) s1_q <= S_W'(1);
				if (s2_q == '0) s2_q <= S_W'(1);
			end
		end
		if (cmd.dev_init) begin
			n_q <= N_W'(2);
			k_q <= K_W'(1);
		end else if (cmd.n_compute) begin
			n_q <= n_calc;
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + K_W'(1);
		end
		if (cmd.knot_load) begin
			t1_q <= t1_n;
			t2_q <= t2_n;
			t3_q <= t3_n;
			t_q  <= t_n;
		end
		if (cmd.mix_store) begin
			case (cmd.mix)
				3'd0:    a1_q <= mix_val;
				3'd1:    a2_q <= mix_val;
				3'd2:    a3_q <= mix_val;
				3'd3:    b1_q <= mix_val;
				3'd4:    b2_q <= mix_val;
				default: r_q  <= mix_val;
			endcase
		end
		if (cmd.dev_store) begin
			if (cmd.axis)
				dy_q <= dvc[DEV_W-1:0];
			else
				dx_q <= dvc[DEV_W-1:0];
		end
		if (cmd.out_store) begin
			if (cmd.axis)
				oy_q <= r_out[COORD_BITS-1:0];
			else
				ox_q <= r_out[COORD_BITS-1:0];
		end
		if (cmd.out_push) begin
			pt_q.out_x       <= ox_q;
			pt_q.out_y       <= oy_q;
			pt_q.piece_index <= k_q;
			pt_q.last_point  <= k_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			pt_valid_q <= 1'b1;
		end else if (pt_ready) begin
			pt_valid_q <= 1'b0;
		end
	end

	assign pt       = pt_q;
	assign pt_valid = pt_valid_q;

	assign stat.sqrt_done = sq_done;
	assign stat.div_done  = div_done;
	assign stat.knot_over = knot_over;
	assign stat.k_last    = k_last;
	assign stat.out_free  = !pt_valid_q || pt_ready;
endmodule

// ----- hw/rtl/crst_ctrl.sv -----
// ----------------------------------------------------------------------------
// crst_ctrl
// Sequencer: chords and knot roots, deviation check, split count, then one
// pyramid evaluation per axis for every emitted point.
// ----------------------------------------------------------------------------
module crst_ctrl import crst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       span_valid,
	output logic       span_ready,
	input  crst_stat_t stat,
	output crst_cmd_t  cmd
);
	typedef enum logic [21:0] {
		ST_IDLE    = 22'd1 << 0,
		ST_CH_X    = 22'd1 << 1,
		ST_CH_Y    = 22'd1 << 2,
		ST_CH_ACC  = 22'd1 << 3,
		ST_SQ_L    = 22'd1 << 4,
		ST_SQ_LW   = 22'd1 << 5,
		ST_SQ_S    = 22'd1 << 6,
		ST_SQ_SW   = 22'd1 << 7,
		ST_HALVE   = 22'd1 << 8,
		ST_KNOT    = 22'd1 << 9,
		ST_MIX_A   = 22'd1 << 10,
		ST_MIX_B   = 22'd1 << 11,
		ST_MIX_C   = 22'd1 << 12,
		ST_MIX_DIV = 22'd1 << 13,
		ST_MIX_W   = 22'd1 << 14,
		ST_AXIS    = 22'd1 << 15,
		ST_D2_X    = 22'd1 << 16,
		ST_D2_Y    = 22'd1 << 17,
		ST_D2_ACC  = 22'd1 << 18,
		ST_TOL_DIV = 22'd1 << 19,
		ST_NEED_W  = 22'd1 << 20,
		ST_PUSH    = 22'd1 << 21
	} state_t;

	state_t state_q, state_d;
	logic [1:0] seg_q, seg_d;
	logic [2:0] mix_q, mix_d;
	logic axis_q, axis_d;
	logic emit_q, emit_d;

	always_comb begin
		state_d = state_q;
		seg_d   = seg_q;
		mix_d   = mix_q;
		axis_d  = axis_q;
		emit_d  = emit_q;
		cmd     = '0;
		cmd.seg  = seg_q;
		cmd.mix  = mix_q;
		cmd.axis = axis_q;
		span_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				span_ready = 1'b1;
				if (span_valid) begin
					cmd.load_in = 1'b1;
					seg_d   = 2'd0;
					state_d = ST_CH_X;
				end
			end
			ST_CH_X: begin
				cmd.mul_sel = MS_CHORD_X;
				state_d = ST_CH_Y;
			end
			ST_CH_Y: begin
				cmd.mul_sel  = MS_CHORD_Y;
				cmd.acc_load = 1'b1;
				state_d = ST_CH_ACC;
			end
			ST_CH_ACC: begin
				cmd.acc_add = 1'b1;
				state_d = ST_SQ_L;
			end
			ST_SQ_L: begin
				cmd.sqrt_go = 1'b1;
				state_d = ST_SQ_LW;
			end
			ST_SQ_LW: begin
				if (stat.sqrt_done)
					state_d = ST_SQ_S;
			end
			ST_SQ_S: begin
				cmd.sqrt_go   = 1'b1;
				cmd.sqrt_knot = 1'b1;
				state_d = ST_SQ_SW;
			end
			ST_SQ_SW: begin
				if (stat.sqrt_done) begin
					cmd.s_store = 1'b1;
					if (seg_q == 2'd2) begin
						state_d = ST_HALVE;
					end else begin
						seg_d   = seg_q + 2'd1;
						state_d = ST_CH_X;
					end
				end
			end
			ST_HALVE: begin
				cmd.halve = 1'b1;
				if (!stat.knot_over) begin
					cmd.dev_init = 1'b1;
					emit_d  = 1'b0;
					state_d = ST_KNOT;
				end
			end
			ST_KNOT: begin
				cmd.knot_load = 1'b1;
				mix_d   = 3'd0;
				axis_d  = 1'b0;
				state_d = ST_MIX_A;
			end
			ST_MIX_A: begin
				cmd.mul_sel = MS_MIX_A;
				state_d = ST_MIX_B;
			end
			ST_MIX_B: begin
				cmd.mul_sel  = MS_MIX_B;
				cmd.acc_load = 1'b1;
				state_d = ST_MIX_C;
			end
			ST_MIX_C: begin
				cmd.acc_add = 1'b1;
				state_d = ST_MIX_DIV;
			end
			ST_MIX_DIV: begin
				cmd.div_go = 1'b1;
				state_d = ST_MIX_W;
			end
			ST_MIX_W: begin
				if (stat.div_done) begin
					cmd.mix_store = 1'b1;
					if (mix_q == 3'd5) begin
						state_d = ST_AXIS;
					end else begin
						mix_d   = mix_q + 3'd1;
						state_d = ST_MIX_A;
					end
				end
			end
			ST_AXIS: begin
				cmd.out_store = emit_q;
				cmd.dev_store = !emit_q;
				if (!axis_q) begin
					axis_d  = 1'b1;
					mix_d   = 3'd0;
					state_d = ST_MIX_A;
				end else if (emit_q) begin
					state_d = ST_PUSH;
				end else begin
					state_d = ST_D2_X;
				end
			end
			ST_D2_X: begin
				cmd.mul_sel = MS_DEV_X;
				state_d = ST_D2_Y;
			end
			ST_D2_Y: begin
				cmd.mul_sel  = MS_DEV_Y;
				cmd.acc_load = 1'b1;
				state_d = ST_D2_ACC;
			end
			ST_D2_ACC: begin
				cmd.acc_add = 1'b1;
				cmd.mul_sel = MS_TOL;
				state_d = ST_TOL_DIV;
			end
			ST_TOL_DIV: begin
				cmd.div_go   = 1'b1;
				cmd.div_need = 1'b1;
				state_d = ST_NEED_W;
			end
			ST_NEED_W: begin
				if (stat.div_done) begin
					cmd.n_compute = 1'b1;
					emit_d  = 1'b1;
					state_d = ST_KNOT;
				end
			end
			ST_PUSH: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					if (stat.k_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d = ST_KNOT;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= '0;
			mix_q   <= '0;
			axis_q  <= 1'b0;
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			mix_q   <= mix_d;
			axis_q  <= axis_d;
			emit_q  <= emit_d;
		end
	end
endmodule

// ----- hw/rtl/catmull_rom_span_tessellator_unit.sv -----
// ----------------------------------------------------------------------------
// catmull_rom_span_tessellator_unit
// Centripetal Catmull-Rom span tessellator with an APB register port.
// ----------------------------------------------------------------------------
// One span (four control points) is taken at a time. The unit works out three
// chord lengths and knot roots, evaluates the span midpoint, compares its
// deviation against curve_tolerance to pick n pieces (1..8), then emits the n
// points k = 0..n-1, the last one flagged. The time per span grows with n, with
// knot halving and with any stall on the point output: every pyramid stage
// ends in a bit-serial divide on the single shared divider, six stages per
// axis per point, and each knot step needs two square roots. A new span is
// accepted as soon as the last point has moved into the output register.
module catmull_rom_span_tessellator_unit import crst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	crst_span_if.sink         span,
	crst_point_if.source      point,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [15:0] tol_q;
	logic [15:0] bias_q;
	logic        span_ready;
	span_t       span_in;
	point_t      pt;
	logic        pt_valid;
	crst_cmd_t   cmd;
	crst_stat_t  stat;

	// register writes complete in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= 16'd154;
			bias_q <= 16'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_TOL:  tol_q  <= pwdata[15:0];
				REG_BIAS: bias_q <= pwdata[15:0];
				default:  tol_q  <= tol_q;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BIAS) ? {16'd0, bias_q} : {16'd0, tol_q};

	assign span_in.p0_x = span.p0_x;
	assign span_in.p0_y = span.p0_y;
	assign span_in.p1_x = span.p1_x;
	assign span_in.p1_y = span.p1_y;
	assign span_in.p2_x = span.p2_x;
	assign span_in.p2_y = span.p2_y;
	assign span_in.p3_x = span.p3_x;
	assign span_in.p3_y = span.p3_y;
	assign span.ready   = span_ready;

	crst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.span_valid(span.valid),
		.span_ready(span_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	crst_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.span_in        (span_in),
		.curve_tolerance(tol_q),
		.knot_bias      (bias_q),
		.pt             (pt),
		.pt_valid       (pt_valid),
		.pt_ready       (point.ready)
	);

	assign point.valid       = pt_valid;
	assign point.out_x       = pt.out_x;
	assign point.out_y       = pt.out_y;
	assign point.piece_index = pt.piece_index;
	assign point.last_point  = pt.last_point;
endmodule
